// File: rtl/pidaw_pkg.sv
// pidaw_pkg: shared types and constants for the pid controller with integral clamp
// request payload structs, register index codes and reset values
// no dependencies
package pidaw_pkg;

	localparam int SampleW     = 16;  // error sample width, signed q8.8
	localparam int CoefW       = 16;  // gain and limit width, signed q8.8
	localparam int SqW         = 31;  // squared error width, unsigned q15.16
	localparam int DriveW      = 16;  // drive width, signed q8.8
	localparam int CfgIdxW     = 3;
	localparam int SumWDefault = 32;

	localparam logic signed [CoefW-1:0] LimitLowReset  = -16'sd256;
	localparam logic signed [CoefW-1:0] LimitHighReset = 16'sd256;

	typedef enum logic [CfgIdxW-1:0] {
		REG_GAIN_P     = 3'd0,
		REG_GAIN_I     = 3'd1,
		REG_GAIN_D     = 3'd2,
		REG_LIMIT_LOW  = 3'd3,
		REG_LIMIT_HIGH = 3'd4
	} pidaw_reg_t;

	typedef struct packed {
		logic signed [SampleW-1:0] error_sample;
		logic                      restart;
	} pidaw_in_t;

	typedef struct packed {
		logic signed [DriveW-1:0] drive;
		logic        [SqW-1:0]    squared_error;
		logic                     clamped;
	} pidaw_out_t;

endpackage

// File: rtl/pid_controller_antiwindup_unit.sv
// pid_controller_antiwindup_unit: fixed-point pid controller with integral clamp
// five-stage pipeline, one request per cycle unless the result channel stalls it; depends on pidaw_pkg
//
//  channel   ports                               direction  payload
//  sample    sample_valid, sample_stall, sample  in         pidaw_in_t (error_sample, restart)
//  result    result_valid, result_stall, result  out        pidaw_out_t (drive, squared_error,
//                                                           clamped)
//  config    cfg_we, cfg_index, cfg_data         in         16-bit register write
//
// one request enters per cycle while sample_stall is low; its result leaves from stage 5
// the running sum and previous sample are updated at the accept edge, so the
// next request sees them at once; the remaining stages are a plain pipeline
// each stage holds its contents under a result stall and accepts into empty
// slots, so bubbles close up and requests still enter while a result waits
// reset clears valid bits, history and registers (limits to -1.0 / +1.0)
module pid_controller_antiwindup_unit
	import pidaw_pkg::*;
#(
	parameter int SUM_WIDTH = SumWDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// sample channel
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  pidaw_in_t            sample,
	// result channel
	output logic                 result_valid,
	input  logic                 result_stall,
	output pidaw_out_t           result,
	// configuration writes
	input  logic                 cfg_we,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [CoefW-1:0]     cfg_data
);

	// widths of the datapath
	localparam int SW  = SampleW;
	localparam int DW  = SW + 1;                      // sample difference
	localparam int BW  = 34;                          // sum bounded to +-2^32
	localparam int SXW = (SUM_WIDTH > BW) ? SUM_WIDTH : BW;
	localparam int PW  = SW + CoefW;                  // p term
	localparam int IW  = BW + CoefW;                  // raw i term
	localparam int DTW = DW + CoefW;                  // d term
	localparam int LW  = CoefW + 8;                   // limit in q.16
	localparam int MW1 = (PW > DTW) ? PW : DTW;
	localparam int MW  = (MW1 > LW) ? MW1 : LW;
	localparam int TW  = MW + 2;                      // sum of three terms
	localparam int QW  = LW + 1 - 8;                  // rounded q9.8 value
	localparam int NW  = QW + 1;                      // negated value

	localparam longint SBoundL = 64'sd4294967296;
	localparam logic signed [SXW-1:0] SBoundHi = SXW'(SBoundL);
	localparam logic signed [SXW-1:0] SBoundLo = SXW'(-SBoundL);
	localparam logic signed [SUM_WIDTH-1:0] SumMax = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH-1:0] SumMin = {1'b1, {(SUM_WIDTH-1){1'b0}}};
	localparam logic signed [NW-1:0] DriveMax = NW'(32767);
	localparam logic signed [NW-1:0] DriveMin = -NW'(32768);

	// configuration registers
	logic signed [CoefW-1:0] gain_p_q, gain_i_q, gain_d_q, limit_low_q, limit_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q     <= '0;
			gain_i_q     <= '0;
			gain_d_q     <= '0;
			limit_low_q  <= LimitLowReset;
			limit_high_q <= LimitHighReset;
		end else if (cfg_we) begin
			unique case (pidaw_reg_t'(cfg_index))
				REG_GAIN_P:     gain_p_q     <= cfg_data;
				REG_GAIN_I:     gain_i_q     <= cfg_data;
				REG_GAIN_D:     gain_d_q     <= cfg_data;
				REG_LIMIT_LOW:  limit_low_q  <= cfg_data;
				REG_LIMIT_HIGH: limit_high_q <= cfg_data;
				default:        ;  // unused indexes are ignored
			endcase
		end
	end

	// limits in q.16, shared by both clamps
	logic signed [LW-1:0] lim_lo, lim_hi;
	assign lim_lo = {limit_low_q, 8'h00};
	assign lim_hi = {limit_high_q, 8'h00};

	// stage valid bits and the ready chain; a stage loads when empty or draining
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic accept;

	assign rdy_s5       = !vld_s5 || !result_stall;
	assign rdy_s4       = !vld_s4 || rdy_s5;
	assign rdy_s3       = !vld_s3 || rdy_s4;
	assign rdy_s2       = !vld_s2 || rdy_s3;
	assign rdy_s1       = !vld_s1 || rdy_s2;
	assign sample_stall = !rdy_s1;
	assign accept       = sample_valid && rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= sample_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
		end
	end

	// history: running sum and previous sample, updated at the accept edge
	logic signed [SUM_WIDTH-1:0] sum_q;
	logic signed [SW-1:0]        prev_q;
	logic signed [SUM_WIDTH-1:0] sum_eff, sum_next;
	logic signed [SW-1:0]        prev_eff;
	logic signed [SUM_WIDTH:0]   sum_wide;
	logic signed [DW-1:0]        diff;

	// restart zeroes the history before this sample is used
	assign sum_eff  = sample.restart ? '0 : sum_q;
	assign prev_eff = sample.restart ? '0 : prev_q;
	assign sum_wide = (SUM_WIDTH+1)'(sum_eff) + (SUM_WIDTH+1)'(sample.error_sample);

	// saturate instead of wrapping when the top two bits disagree
	always_comb begin
		if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
			sum_next = sum_wide[SUM_WIDTH] ? SumMin : SumMax;
		end else begin
			sum_next = sum_wide[SUM_WIDTH-1:0];
		end
	end

	assign diff = DW'(sample.error_sample) - DW'(prev_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			prev_q <= '0;
		end else if (accept) begin
			sum_q  <= sum_next;
			prev_q <= sample.error_sample;
		end
	end

	// stage 1: sample, difference and updated sum
	logic signed [SW-1:0]        e_s1;
	logic signed [DW-1:0]        d_s1;
	logic signed [SUM_WIDTH-1:0] sum_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			e_s1   <= sample.error_sample;
			d_s1   <= diff;
			sum_s1 <= sum_next;
		end
	end

	// stage 2: sum bounded to +-2^32, which keeps every clamp decision intact
	logic signed [SXW-1:0] sum_x;
	logic signed [BW-1:0]  s_bnd;
	logic signed [SW-1:0]  e_s2;
	logic signed [DW-1:0]  d_s2;
	logic signed [BW-1:0]  s_s2;

	assign sum_x = SXW'(sum_s1);

	always_comb begin
		if (sum_x > SBoundHi) begin
			s_bnd = BW'(SBoundHi);
		end else if (sum_x < SBoundLo) begin
			s_bnd = BW'(SBoundLo);
		end else begin
			s_bnd = BW'(sum_x);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			e_s2 <= e_s1;
			d_s2 <= d_s1;
			s_s2 <= s_bnd;
		end
	end

	// stage 3: the four products in parallel
	logic signed [PW-1:0]   pt_s3;
	logic signed [IW-1:0]   it_s3;
	logic signed [DTW-1:0]  dt_s3;
	logic signed [2*SW-1:0] sq_s3;
	logic signed [PW-1:0]   pt_mul;
	logic signed [IW-1:0]   it_mul;
	logic signed [DTW-1:0]  dt_mul;
	logic signed [2*SW-1:0] sq_mul;

	assign pt_mul = PW'(e_s2) * PW'(gain_p_q);
	assign it_mul = IW'(s_s2) * IW'(gain_i_q);
	assign dt_mul = DTW'(d_s2) * DTW'(gain_d_q);
	assign sq_mul = (2*SW)'(e_s2) * (2*SW)'(e_s2);

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			pt_s3 <= pt_mul;
			it_s3 <= it_mul;
			dt_s3 <= dt_mul;
			sq_s3 <= sq_mul;
		end
	end

	// stage 4: clamp the i term (high first), add the three terms, saturate the square
	logic signed [LW-1:0] it_c;
	logic signed [TW-1:0] total;
	logic        [SqW-1:0] sq_sat;
	logic signed [TW-1:0] total_s4;
	logic        [SqW-1:0] sq_s4;

	always_comb begin
		if (it_s3 > IW'(lim_hi)) begin
			it_c = lim_hi;
		end else if (it_s3 < IW'(lim_lo)) begin
			it_c = lim_lo;
		end else begin
			it_c = LW'(it_s3);
		end
	end

	assign total  = TW'(pt_s3) + TW'(it_c) + TW'(dt_s3);
	// square is never negative; saturate anything above the field
	assign sq_sat = (|sq_s3[2*SW-1:SqW]) ? '1 : sq_s3[SqW-1:0];

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			total_s4 <= total;
			sq_s4    <= sq_sat;
		end
	end

	// stage 5: output clamp, round half up to q8.8, negate with saturation
	logic signed [LW-1:0] tot_c;
	logic                 hit;
	logic signed [LW:0]   rnd;
	logic signed [QW-1:0] q_val;
	logic signed [NW-1:0] neg;
	logic signed [DriveW-1:0] drv;
	pidaw_out_t           out_s5;

	// a value equal to a limit is not flagged
	always_comb begin
		if (total_s4 > TW'(lim_hi)) begin
			tot_c = lim_hi;
			hit   = 1'b1;
		end else if (total_s4 < TW'(lim_lo)) begin
			tot_c = lim_lo;
			hit   = 1'b1;
		end else begin
			tot_c = LW'(total_s4);
			hit   = 1'b0;
		end
	end

	assign rnd   = (LW+1)'(tot_c) + (LW+1)'(128);
	assign q_val = QW'(rnd >>> 8);
	assign neg   = -NW'(q_val);

	always_comb begin
		if (neg > DriveMax) begin
			drv = DriveW'(DriveMax);
		end else if (neg < DriveMin) begin
			drv = DriveW'(DriveMin);
		end else begin
			drv = DriveW'(neg);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			out_s5.drive         <= drv;
			out_s5.squared_error <= sq_s4;
			out_s5.clamped       <= hit;
		end
	end

	assign result_valid = vld_s5;
	assign result       = out_s5;

endmodule
